// File: rtl/rsp_pkg.sv
// shared constants and types for the running statistics core
package rsp_pkg;

  localparam int unsigned DEF_MAX_SAMPLES = 256;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd32768;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REPORT = 1'b1
  } action_t;

  // word handed from the front classifier to the back engine
  typedef struct packed {
    logic              add;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SHIFT,
    BK_PREP,
    BK_RD_LO,
    BK_RD_HI,
    BK_WAIT,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// File: rtl/rsp_if.sv
// valid/ready channel interfaces for the running statistics core
interface rsp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [31:0] sample_value;
  modport source (output valid, output action, output sample_value, input ready);
  modport sink (input valid, input action, input sample_value, output ready);
endinterface

interface rsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  sample_count;
  logic signed [31:0] minimum;
  logic signed [31:0] maximum;
  logic signed [31:0] average;
  logic signed [31:0] percentile_value;
  modport source (output valid, output status, output sample_count, output minimum,
                  output maximum, output average, output percentile_value, input ready);
  modport sink (input valid, input status, input sample_count, input minimum,
                input maximum, input average, input percentile_value, output ready);
endinterface

interface rsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rsp_front.sv
// front end: takes input words and queues decoded commands
module rsp_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  rsp_in_if.sink    in_ch,
  output rsp_pkg::cmd_t cmd,
  output logic      cmd_valid,
  input  logic      cmd_take
);
  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  rsp_pkg::cmd_t   fifo [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;
  logic            push;
  logic            pop;

  assign in_ch.ready = (fill != PW'(0) + (PW+1)'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop = cmd_valid && cmd_take;
  assign cmd_valid = (fill != '0);
  assign cmd = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].add <= (in_ch.action == rsp_pkg::ACT_ADD);
      fifo[wr_ptr].value <= in_ch.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QDEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(QDEPTH-1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(QDEPTH)) else $error("queue overfilled");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 1'b1) else $error("fill count slip");
endmodule

// File: rtl/rsp_back.sv
// back end: sorted store, running extremes, percentile and average
module rsp_back #(
  parameter int unsigned MAX_SAMPLES = rsp_pkg::DEF_MAX_SAMPLES
) (
  input  logic clk,
  input  logic rst,
  input  rsp_pkg::cmd_t cmd,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  logic [16:0] pfrac,
  rsp_out_if.source out_ch
);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  logic signed [31:0] mem [MAX_SAMPLES];
  rsp_pkg::back_state_t state, state_next;

  logic [CW-1:0]      count;
  logic signed [31:0] rmin, rmax;
  logic signed [39:0] rsum;
  logic signed [31:0] val;
  logic [CW-1:0]      pos;
  logic [1:0]         stat;
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic signed [31:0] lower;
  logic [15:0]        frac;
  logic [CW-1:0]      idx;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [39:0]        dmag;
  logic [39:0]        quo;
  logic [CW-1:0]      rem;
  logic [5:0]         dstep;
  logic               dneg;
  logic [CW:0]        rem_sh;
  logic               stepdone;
  logic [16:0]        pclamp;
  logic [CW+16:0]     rank;

  // percentile clamp and rank
  always_comb begin
    pclamp = pfrac;
    if (pfrac == '0) pclamp = 17'd1;
    else if (pfrac > rsp_pkg::FRAC_ONE) pclamp = rsp_pkg::FRAC_ONE;
    rank = (CW+17)'(pclamp) * (CW+17)'(count);
  end

  always_comb begin
    rem_sh = {rem, dmag[39]};
    stepdone = (dstep == 6'd39);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rsp_pkg::BK_IDLE: if (cmd_valid && !out_ch.valid) begin
        if (cmd.add && count != CW'(MAX_SAMPLES)) state_next = rsp_pkg::BK_SCAN;
        else state_next = rsp_pkg::BK_PREP;
      end
      rsp_pkg::BK_SCAN: state_next = rsp_pkg::BK_SHIFT;
      rsp_pkg::BK_SHIFT:
        if (pos == '0 || rd_data <= val) state_next = rsp_pkg::BK_PREP;
      rsp_pkg::BK_PREP:
        state_next = (count == '0) ? rsp_pkg::BK_DONE : rsp_pkg::BK_RD_LO;
      rsp_pkg::BK_RD_LO: state_next = rsp_pkg::BK_RD_HI;
      rsp_pkg::BK_RD_HI: state_next = rsp_pkg::BK_WAIT;
      rsp_pkg::BK_WAIT: state_next = rsp_pkg::BK_MUL;
      rsp_pkg::BK_MUL: state_next = rsp_pkg::BK_DIV;
      rsp_pkg::BK_DIV: if (stepdone) state_next = rsp_pkg::BK_DONE;
      rsp_pkg::BK_DONE: state_next = rsp_pkg::BK_IDLE;
      default: state_next = rsp_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state == rsp_pkg::BK_IDLE) && cmd_valid && !out_ch.valid;
    rd_en = 1'b0;
    rd_addr = '0;
    unique case (state)
      rsp_pkg::BK_SCAN: begin
        rd_en = 1'b1;
        rd_addr = AW'(pos - 1'b1);
      end
      rsp_pkg::BK_SHIFT: begin
        rd_en = 1'b1;
        rd_addr = AW'(pos - 2'd2);
      end
      rsp_pkg::BK_RD_LO: begin
        rd_en = 1'b1;
        rd_addr = (idx == '0) ? '0 : AW'(idx - 1'b1);
      end
      rsp_pkg::BK_RD_HI: begin
        rd_en = 1'b1;
        rd_addr = (idx >= count) ? AW'(count - 1'b1) : AW'(idx);
      end
      default: ;
    endcase
  end

  // store: one read port and one write port
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (state == rsp_pkg::BK_SHIFT) begin
      if (pos != '0 && rd_data > val) mem[AW'(pos)] <= rd_data;
      else mem[AW'(pos)] <= val;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rsp_pkg::BK_IDLE: begin
        val <= cmd.value;
        pos <= count;
        stat <= (cmd.add && count == CW'(MAX_SAMPLES)) ? rsp_pkg::ST_FULL
                                                        : rsp_pkg::ST_OK;
      end
      rsp_pkg::BK_SHIFT: if (pos != '0 && rd_data > val) pos <= pos - 1'b1;
      rsp_pkg::BK_PREP: begin
        idx <= CW'(rank >> 16);
        frac <= rank[15:0];
        dneg <= rsum[39];
        dmag <= rsum[39] ? 40'(-rsum) : 40'(rsum);
        rem <= '0;
        dstep <= '0;
      end
      rsp_pkg::BK_RD_HI: lower <= rd_data;
      rsp_pkg::BK_WAIT: diff <= 33'(rd_data) - 33'(lower);
      rsp_pkg::BK_MUL: prod <= diff * $signed({1'b0, frac});
      rsp_pkg::BK_DIV: begin
        // restoring division, one quotient bit a cycle
        dstep <= dstep + 1'b1;
        dmag <= {dmag[38:0], 1'b0};
        if (rem_sh >= {1'b0, count}) begin
          rem <= CW'(rem_sh - {1'b0, count});
          quo <= {quo[38:0], 1'b1};
        end else begin
          rem <= CW'(rem_sh);
          quo <= {quo[38:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsp_pkg::BK_IDLE;
      count <= '0;
      rmin <= 32'sh7fffffff;
      rmax <= 32'sh80000000;
      rsum <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rsp_pkg::BK_SCAN) begin
        count <= count + 1'b1;
        if (val > rmax) rmax <= val;
        if (val < rmin) rmin <= val;
        rsum <= rsum + 40'(val);
      end
      if (state == rsp_pkg::BK_DONE) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rsp_pkg::BK_DONE) begin
      if (count == '0) begin
        out_ch.status <= rsp_pkg::ST_EMPTY;
        out_ch.sample_count <= '0;
        out_ch.minimum <= '0;
        out_ch.maximum <= '0;
        out_ch.average <= '0;
        out_ch.percentile_value <= '0;
      end else begin
        out_ch.status <= stat;
        out_ch.sample_count <= 9'(count);
        out_ch.minimum <= rmin;
        out_ch.maximum <= rmax;
        out_ch.average <= dneg ? 32'(-quo) : 32'(quo);
        out_ch.percentile_value <= lower + 32'(prod >>> 16);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("count past capacity");
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    state == rsp_pkg::BK_IDLE && state_next == rsp_pkg::BK_PREP |=> count == $past(count))
    else $error("count moved on a report");
  a_one_insert: assert property (@(posedge clk) disable iff (rst)
    state == rsp_pkg::BK_SCAN |=> count == $past(count) + 1'b1) else $error("insert count");
endmodule

// File: rtl/running_stats_percentile_core.sv
// top level of the running statistics and percentile core
// usage:
//   in_ch carries one word per item: action (0 add then report, 1 report)
//   and sample_value in signed q16.16. each accepted word yields exactly
//   one result word on out_ch: status, sample_count, minimum, maximum,
//   average and the interpolated percentile_value.
//   cfg_ch writes the 17-bit percentile fraction (q1.16); write it only
//   while the core is idle. it is always ready.
// operation:
//   a report word passes through the queue to the engine, which sets up,
//   reads the two percentile neighbors, runs the restoring divider by the
//   count and loads the output register. a report on an empty store skips
//   the reads and the divider; a dropped add on a full store takes the
//   report path. an add first inserts its sample: the sorted insert shifts
//   each stored entry larger than the new sample, one entry a cycle.
//   one word is worked at a time; a two-word queue sits in front.
// reset: rst (synchronous) empties the store, clears the count and sum
//   and sets the fraction to one half.
// stall: a held result waits in the output register; the engine takes the
//   next word the cycle after it is taken, and meanwhile the queue fills.
module running_stats_percentile_core #(
  parameter int unsigned MAX_SAMPLES = rsp_pkg::DEF_MAX_SAMPLES
) (
  input  logic clk,
  input  logic rst,
  rsp_in_if.sink     in_ch,
  rsp_cfg_if.sink    cfg_ch,
  rsp_out_if.source  out_ch
);
  rsp_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;
  logic [16:0]   pfrac;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) pfrac <= rsp_pkg::FRAC_RESET;
    else if (cfg_ch.valid) pfrac <= cfg_ch.data;
  end

  rsp_front #(.QDEPTH(2)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  rsp_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_take(cmd_take), .pfrac(pfrac), .out_ch(out_ch)
  );
endmodule

// File: tb/running_stats_percentile_core_tb.sv
// self-checking testbench for the running statistics and percentile core
module running_stats_percentile_core_tb;

  localparam int unsigned DEPTH = rsp_pkg::DEF_MAX_SAMPLES;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DRAIN_CYCLES = 400;

  // one result word as the core reports it
  typedef struct packed {
    rsp_pkg::status_t status;
    logic [8:0]  count;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic [31:0] average;
    logic [31:0] pct;
  } stats_word_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct {
    rsp_pkg::action_t act;
    logic [31:0] value;
    bit          typed;
    stats_word_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsp_in_if  in_ch ();
  rsp_cfg_if cfg_ch ();
  rsp_out_if out_ch ();

  running_stats_percentile_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .cfg_ch (cfg_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // model state of the core
  logic signed [31:0] kept [DEPTH];
  int unsigned        kept_count;
  longint             run_min;
  longint             run_max;
  longint             run_sum;
  logic [16:0]        frac_reg;

  stats_word_t pending_stats[$];
  int unsigned mismatch_count;
  int unsigned words_checked;
  int unsigned adds_sent;
  int unsigned drops_seen;
  int unsigned empties_seen;
  bit          quiet_sink;

  // directed table: empty report, field extremes, duplicates and both actions
  plan_row_t plan [16] = '{
    '{rsp_pkg::ACT_REPORT, 32'h0000_0000, 1'b1,
      '{rsp_pkg::ST_EMPTY, 9'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{rsp_pkg::ACT_ADD,    32'h7FFF_FFFF, 1'b1,
      '{rsp_pkg::ST_OK, 9'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
    '{rsp_pkg::ACT_ADD,    32'h8000_0000, 1'b0, '0},
    '{rsp_pkg::ACT_REPORT, 32'hFFFF_FFFF, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h0000_0000, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'hFFFF_FFFF, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h0000_0001, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h7FFF_FFFF, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h8000_0000, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h0001_0000, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'hFFFF_0000, 1'b0, '0},
    '{rsp_pkg::ACT_REPORT, 32'h5555_5555, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'hAAAA_AAAA, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h5555_5555, 1'b0, '0},
    '{rsp_pkg::ACT_ADD,    32'h0000_0000, 1'b0, '0},
    '{rsp_pkg::ACT_REPORT, 32'h0000_0000, 1'b0, '0}
  };

  // apply one word to the model and return what the core should report
  function automatic stats_word_t predict_stats(rsp_pkg::action_t act, logic [31:0] value);
    stats_word_t      w;
    rsp_pkg::status_t st;
    int               pos;
    longint           p, rank, idx, f, lo, hi;
    st = rsp_pkg::ST_OK;
    if (act == rsp_pkg::ACT_ADD) begin
      if (kept_count >= DEPTH) begin
        st = rsp_pkg::ST_FULL;
      end else begin
        pos = kept_count;
        while (pos > 0 && kept[pos-1] > $signed(value)) begin
          kept[pos] = kept[pos-1];
          pos--;
        end
        kept[pos] = value;
        kept_count++;
        if ($signed(value) > run_max) run_max = $signed(value);
        if ($signed(value) < run_min) run_min = $signed(value);
        run_sum += $signed(value);
      end
    end
    if (kept_count == 0) begin
      w = '{rsp_pkg::ST_EMPTY, 9'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      return w;
    end
    // fraction zero acts as one lsb, anything above one saturates to one
    p = frac_reg;
    if (p == 0) p = 1;
    if (p > rsp_pkg::FRAC_ONE) p = rsp_pkg::FRAC_ONE;
    rank = p * kept_count;
    idx = rank >> 16;
    f = rank & 64'hFFFF;
    lo = (idx == 0) ? kept[0] : kept[idx-1];
    // rank at the count reads the last entry
    hi = (idx >= kept_count) ? kept[kept_count-1] : kept[idx];
    w.status = st;
    w.count = kept_count[8:0];
    w.minimum = run_min[31:0];
    w.maximum = run_max[31:0];
    w.average = 32'(run_sum / longint'(kept_count));
    w.pct = 32'(lo + (((hi - lo) * f) >>> 16));
    return w;
  endfunction

  // append one expected word at the tail of the queue
  function automatic void enqueue_expected(stats_word_t w);
    pending_stats.insert(pending_stats.size(), w);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] word %0d: %s got %h want %h", $realtime, words_checked, field, got, want);
  endtask

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    stats_word_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected word", 32'(out_ch.status), 32'd0);
      end else begin
        w = pending_stats.pop_front();
        if (out_ch.status != w.status)
          report_mismatch("status", 32'(out_ch.status), 32'(w.status));
        if (out_ch.sample_count != w.count)
          report_mismatch("sample_count", 32'(out_ch.sample_count), 32'(w.count));
        if (out_ch.minimum != w.minimum) report_mismatch("minimum", out_ch.minimum, w.minimum);
        if (out_ch.maximum != w.maximum) report_mismatch("maximum", out_ch.maximum, w.maximum);
        if (out_ch.average != w.average) report_mismatch("average", out_ch.average, w.average);
        if (out_ch.percentile_value != w.pct)
          report_mismatch("percentile_value", out_ch.percentile_value, w.pct);
        if (w.status == rsp_pkg::ST_FULL) drops_seen++;
        if (w.status == rsp_pkg::ST_EMPTY) empties_seen++;
      end
      words_checked++;
    end
  end

  // result side: ready in random bursts, steady once quiet_sink is set
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_sink && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // send one word; valid stays up between back-to-back words
  task automatic send_word(rsp_pkg::action_t act, logic [31:0] value, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.sample_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    enqueue_expected(predict_stats(act, value));
    if (act == rsp_pkg::ACT_ADD) adds_sent++;
  endtask

  task automatic write_fraction(logic [16:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    frac_reg = value;
  endtask

  // hold the sender until every expected word is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sample values: full range, extremes, clustered small values with duplicates
  function automatic logic [31:0] pick_sample();
    unique case ($urandom_range(0, 5))
      0: begin
        unique case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [16:0]      phase_frac [NUM_PHASES];
    rsp_pkg::action_t act;
    kept_count = 0;
    run_min = 64'sh7FFF_FFFF;
    run_max = -64'sh8000_0000;
    run_sum = 0;
    frac_reg = rsp_pkg::FRAC_RESET;
    mismatch_count = 0;
    words_checked = 0;
    adds_sent = 0;
    drops_seen = 0;
    empties_seen = 0;
    quiet_sink = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = rsp_pkg::ACT_REPORT;
    in_ch.sample_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run at the reset fraction of one half
    foreach (plan[i]) begin
      send_word(plan[i].act, plan[i].value, 1'b1);
      if (plan[i].typed) pending_stats[pending_stats.size() - 1] = plan[i].want;
    end

    // fraction settings per phase: zero, one, one lsb, saturation, just above one, then random
    phase_frac[0] = 17'd0;
    phase_frac[1] = rsp_pkg::FRAC_ONE;
    phase_frac[2] = 17'd1;
    phase_frac[3] = 17'h1FFFF;
    phase_frac[4] = 17'd65537;
    phase_frac[5] = 17'($urandom_range(1, 65535));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // the core is idle here: every result is in before the write
      drain_results();
      write_fraction(phase_frac[ph]);
      if (ph == NUM_PHASES - 1) quiet_sink = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // adds dominate so the store fills and then overflows
        act = ($urandom_range(0, 4) == 0) ? rsp_pkg::ACT_REPORT : rsp_pkg::ACT_ADD;
        send_word(act, pick_sample(), ph != NUM_PHASES - 1);
      end
    end

    drain_results();
    $display("%0d words checked, %0d adds, %0d dropped on a full store, %0d empty reports",
             words_checked, adds_sent, drops_seen, empties_seen);
    $display("fraction settings covered zero, one lsb, one, above one and a random value");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog on a run that hangs
  initial begin
    #20_000_000;
    $display("timeout with %0d words still expected", pending_stats.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: running_stats_percentile_core.f
rtl/rsp_pkg.sv
rtl/rsp_if.sv
rtl/rsp_front.sv
rtl/rsp_back.sv
rtl/running_stats_percentile_core.sv
tb/running_stats_percentile_core_tb.sv
